/* sv/dpk_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dpk_pkg
// Shared types, request/status codes and constant tables of the
// dual permutation keystream generator.
// ----------------------------------------------------------------------------
package dpk_pkg;

  localparam int MAX_KEY_LEN = 32;
  localparam int MAX_IV_LEN  = 32;
  localparam int KEY_AW      = $clog2(MAX_KEY_LEN);
  localparam int IV_AW       = $clog2(MAX_IV_LEN);
  localparam int KCNT_W      = $clog2(MAX_KEY_LEN + 1);
  localparam int ICNT_W      = $clog2(MAX_IV_LEN + 1);
  localparam int SEED_AW     = (KEY_AW > IV_AW) ? KEY_AW : IV_AW;
  localparam int SEED_CW     = SEED_AW + 1;
  localparam int SEED_DEPTH  = 1 << SEED_AW;

  localparam logic [2:0] REQ_KEY   = 3'd0;
  localparam logic [2:0] REQ_IV    = 3'd1;
  localparam logic [2:0] REQ_SETUP = 3'd2;
  localparam logic [2:0] REQ_NEXT  = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOKEY    = 2'd1;
  localparam logic [1:0] ST_NOTKEYED = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
  } dpk_res_t;

  localparam logic [7:0] NL_ROM [256] = '{
    8'h96,8'h62,8'h29,8'he5,8'h0c,8'hb7,8'hbb,8'h1e,8'h7c,8'h1b,8'h80,8'hcd,8'h8d,8'h3b,8'h83,8'h3c,
    8'h17,8'hcb,8'h11,8'h87,8'h16,8'h1d,8'hc0,8'ha1,8'he9,8'hdd,8'h2f,8'h8f,8'h89,8'hfa,8'h58,8'h28,
    8'h8b,8'hf2,8'h3a,8'hf4,8'h73,8'hca,8'h55,8'he7,8'h94,8'h9b,8'hbf,8'haf,8'h1c,8'hc9,8'h2b,8'h74,
    8'hba,8'h53,8'h98,8'h75,8'hbc,8'haa,8'h6c,8'hec,8'hb1,8'hc4,8'h08,8'h01,8'hc6,8'h59,8'ha4,8'h4a,
    8'hfe,8'hc2,8'h86,8'hdf,8'hff,8'h56,8'h6a,8'h79,8'hd8,8'hb8,8'hb3,8'hc5,8'h72,8'hdc,8'h6d,8'h32,
    8'h69,8'h4f,8'h7a,8'hf9,8'h7d,8'hdb,8'hb4,8'h92,8'h9c,8'ha9,8'h64,8'he1,8'h12,8'hd6,8'hfc,8'h15,
    8'h9a,8'h02,8'h06,8'hcf,8'h19,8'hd0,8'hd2,8'hbe,8'hb9,8'h50,8'h47,8'h23,8'h5f,8'h7f,8'he6,8'h5d,
    8'hb5,8'h3e,8'h48,8'h33,8'hea,8'ha6,8'h30,8'h43,8'he0,8'h52,8'h67,8'h34,8'h31,8'hfd,8'h00,8'hae,
    8'hc1,8'hf6,8'h18,8'h27,8'h97,8'hf8,8'he4,8'h7b,8'h8c,8'h2c,8'hb2,8'h22,8'h9f,8'h10,8'hab,8'hf7,
    8'he2,8'h5c,8'h4d,8'h5b,8'h05,8'h1a,8'h39,8'h03,8'h0f,8'h38,8'h04,8'hd1,8'hee,8'h60,8'h99,8'h41,
    8'he8,8'ha7,8'h70,8'hde,8'hed,8'h81,8'h7e,8'h57,8'hd5,8'h82,8'h85,8'h88,8'h6b,8'h0d,8'hd4,8'ha3,
    8'ha8,8'hef,8'h84,8'had,8'h20,8'h21,8'h4c,8'h35,8'h66,8'h42,8'h91,8'h0a,8'h6f,8'h8e,8'h90,8'h0b,
    8'hf5,8'h4b,8'h2d,8'hd7,8'hd3,8'h71,8'h44,8'h07,8'h9d,8'hfb,8'h40,8'h68,8'hbd,8'h14,8'h2e,8'h09,
    8'hcc,8'h1f,8'ha5,8'h93,8'hc8,8'hc3,8'h54,8'h65,8'h76,8'ha0,8'h77,8'h95,8'ha2,8'h49,8'hd9,8'hac,
    8'h8a,8'h3f,8'h24,8'h36,8'h45,8'hf1,8'h13,8'h9e,8'h3d,8'h46,8'hf0,8'hb6,8'h5e,8'h37,8'hc7,8'h6e,
    8'h2a,8'hce,8'h63,8'h26,8'he3,8'h0e,8'h78,8'hb0,8'h4e,8'h5a,8'hf3,8'heb,8'h51,8'h61,8'h25,8'hda};

  localparam logic [7:0] TK_ROM [256] = '{
    8'h90,8'h16,8'h7c,8'ha3,8'h44,8'h8c,8'hed,8'h83,8'hfc,8'h65,8'hc2,8'h05,8'h46,8'h19,8'h1d,8'h51,
    8'h41,8'haa,8'h4f,8'hbb,8'h02,8'h61,8'h94,8'hf5,8'hac,8'hc8,8'h11,8'h07,8'h1f,8'h34,8'hde,8'hd7,
    8'h92,8'hc4,8'h39,8'hfb,8'hfa,8'he8,8'h62,8'h9c,8'h17,8'h04,8'hb6,8'hdb,8'h01,8'h06,8'hfe,8'hf2,
    8'hb3,8'h0c,8'hf9,8'h03,8'he3,8'hef,8'hb5,8'h31,8'h2c,8'hb2,8'h5e,8'h15,8'h00,8'h23,8'hee,8'h53,
    8'h09,8'hd6,8'h3c,8'h5d,8'h36,8'h14,8'hcf,8'h72,8'h6a,8'hae,8'h71,8'ha6,8'h56,8'h84,8'hb7,8'haf,
    8'h5a,8'h79,8'h73,8'h7d,8'h2f,8'h18,8'he4,8'h49,8'h38,8'he1,8'h08,8'h47,8'h7a,8'h3a,8'hdf,8'h6c,
    8'h91,8'h66,8'h8a,8'h99,8'h86,8'h58,8'h1c,8'hb4,8'h43,8'h8d,8'hbd,8'h4e,8'h24,8'h75,8'hf8,8'he7,
    8'h9f,8'h6b,8'ha5,8'hce,8'hcb,8'hcc,8'h6f,8'h8e,8'hc6,8'h80,8'h54,8'h9e,8'h3f,8'h4a,8'h0a,8'h29,
    8'he0,8'h7e,8'h45,8'hbc,8'h0b,8'h89,8'hd4,8'hd9,8'h95,8'hd8,8'h55,8'ha9,8'h3d,8'h5b,8'hff,8'h32,
    8'hb8,8'h8b,8'h0f,8'h37,8'hcd,8'h2b,8'h57,8'h69,8'h78,8'ha8,8'h74,8'h50,8'hd0,8'h85,8'h81,8'h97,
    8'hea,8'h4c,8'h6d,8'h13,8'hd2,8'he2,8'h70,8'h10,8'hf6,8'h2d,8'hc1,8'hd1,8'h7b,8'h96,8'h1b,8'h26,
    8'h68,8'hba,8'hb1,8'h12,8'h9d,8'hf0,8'hab,8'he9,8'h1e,8'hbe,8'h30,8'ha7,8'hc3,8'h8f,8'hf4,8'h33,
    8'ha1,8'hf1,8'h20,8'hf7,8'h3e,8'hda,8'h0e,8'hd3,8'hb0,8'h42,8'h64,8'h67,8'h98,8'he5,8'hd5,8'h6e,
    8'had,8'he6,8'h9b,8'h2e,8'h88,8'hca,8'h25,8'h2a,8'h0d,8'h4b,8'h52,8'h93,8'h1a,8'ha2,8'hc7,8'hc0,
    8'h77,8'h35,8'h27,8'hf3,8'h87,8'h21,8'h48,8'h82,8'hbf,8'hdc,8'hb9,8'h76,8'hdd,8'h5c,8'h60,8'h59,
    8'h40,8'h22,8'hec,8'ha0,8'h4d,8'h28,8'h7f,8'heb,8'h3b,8'hc9,8'h9a,8'h5f,8'hfd,8'h63,8'hc5,8'ha4};

  localparam logic [7:0] MK_ROM [256] = '{
    8'hcd,8'hb1,8'hf3,8'h3a,8'h99,8'h38,8'hf4,8'h97,8'ha0,8'h1a,8'h62,8'hc1,8'h12,8'h52,8'hea,8'he8,
    8'hf5,8'hec,8'h2c,8'h09,8'h7f,8'h6e,8'h79,8'hd1,8'hdf,8'h88,8'h75,8'hba,8'h87,8'h9f,8'hee,8'h53,
    8'haa,8'h3f,8'h56,8'hc2,8'hb5,8'h48,8'hd7,8'h4e,8'he4,8'h03,8'h33,8'hf9,8'h4f,8'h08,8'h91,8'hd6,
    8'h1d,8'hb9,8'hc3,8'h54,8'h72,8'h06,8'h8b,8'h0d,8'hb8,8'hd8,8'h9c,8'hf8,8'h83,8'hc8,8'h4a,8'h77,
    8'hfe,8'h44,8'h32,8'hd2,8'h89,8'hcc,8'h20,8'h43,8'h9e,8'h46,8'he5,8'h27,8'h17,8'h63,8'ha3,8'h96,
    8'h30,8'h3d,8'hde,8'he1,8'h4c,8'h29,8'hc7,8'h95,8'h57,8'h05,8'h04,8'h37,8'hac,8'h64,8'h94,8'h7d,
    8'hb7,8'h59,8'h82,8'hd4,8'h7c,8'hf6,8'hce,8'h81,8'he7,8'hdc,8'h4b,8'h8e,8'had,8'h60,8'h73,8'h14,
    8'h61,8'hcb,8'h66,8'ha6,8'h2f,8'h31,8'h78,8'h5c,8'h5b,8'h41,8'hc0,8'h4d,8'h34,8'hc4,8'hf0,8'h16,
    8'h6b,8'h76,8'h15,8'h36,8'ha9,8'h71,8'h26,8'ha4,8'he0,8'h9a,8'h85,8'h47,8'h13,8'h3c,8'h11,8'h58,
    8'h2d,8'h1f,8'h0c,8'h7a,8'hd3,8'h7e,8'h6f,8'h6c,8'hbe,8'h02,8'hfd,8'h3b,8'hcf,8'h0f,8'ha8,8'hb0,
    8'h90,8'hfa,8'h5d,8'hda,8'h28,8'h23,8'hbf,8'h42,8'hf1,8'h6a,8'hab,8'hc9,8'hae,8'hc6,8'he6,8'hd9,
    8'h1e,8'h8f,8'hbd,8'h50,8'h86,8'he2,8'he3,8'h40,8'h67,8'hdd,8'haf,8'h10,8'hb4,8'h9b,8'h51,8'h22,
    8'h0b,8'h5e,8'hf7,8'h21,8'h25,8'hd5,8'h2b,8'hca,8'h3e,8'h65,8'h1b,8'hbc,8'hc5,8'ha7,8'hff,8'h8d,
    8'h74,8'h1c,8'h49,8'h92,8'hb6,8'h45,8'ha5,8'hfc,8'h98,8'h00,8'h68,8'hef,8'hd0,8'h70,8'hb2,8'h39,
    8'h01,8'hb3,8'h2a,8'h5f,8'heb,8'h5a,8'h8c,8'h8a,8'h07,8'h0e,8'hf2,8'h19,8'h7b,8'hbb,8'h18,8'h80,
    8'h84,8'h24,8'ha2,8'h0a,8'h69,8'h93,8'ha1,8'hed,8'h9d,8'h55,8'hdb,8'h6d,8'h2e,8'he9,8'h35,8'hfb};

  localparam logic [7:0] MG_ROM [256] = '{
    8'hf2,8'h94,8'h5a,8'h4b,8'h0f,8'h73,8'hda,8'hdb,8'h83,8'h1d,8'hb3,8'h09,8'hfc,8'h36,8'hb8,8'h46,
    8'h41,8'hd4,8'hd0,8'h55,8'hf3,8'h87,8'h76,8'h9a,8'h28,8'h35,8'h71,8'hfb,8'hf7,8'h1c,8'h03,8'h7d,
    8'h15,8'h84,8'h0a,8'h43,8'hfa,8'h9e,8'h60,8'h97,8'h98,8'h7e,8'ha3,8'h52,8'hd1,8'h29,8'ha5,8'h59,
    8'hc5,8'h7a,8'h2f,8'h25,8'he1,8'h3b,8'h38,8'h0c,8'h90,8'hc6,8'hd9,8'hf6,8'hd8,8'hcf,8'h16,8'h95,
    8'h21,8'ha7,8'h6d,8'h1f,8'h58,8'h51,8'h48,8'h2a,8'hbe,8'hab,8'hf1,8'h5d,8'h9b,8'hf9,8'h80,8'hed,
    8'he5,8'ha6,8'hf5,8'h6f,8'h31,8'hba,8'h79,8'h4f,8'h85,8'h81,8'hb1,8'h23,8'he4,8'h72,8'hea,8'h2c,
    8'hca,8'h6b,8'h6a,8'h1e,8'h5c,8'h04,8'hd5,8'hae,8'hb2,8'he6,8'hc3,8'h39,8'h4d,8'h5f,8'h3a,8'h45,
    8'hb4,8'h67,8'hc8,8'h4e,8'h1a,8'ha4,8'h30,8'he0,8'hcc,8'h10,8'hbd,8'h33,8'hce,8'hb7,8'he3,8'h34,
    8'hc4,8'h8a,8'hff,8'hb0,8'h3f,8'h02,8'h7c,8'hdc,8'hbf,8'h08,8'hdf,8'h8d,8'hfd,8'h6c,8'heb,8'h12,
    8'h6e,8'h24,8'hcd,8'h2e,8'h99,8'h5e,8'h14,8'h8e,8'h50,8'h7f,8'haa,8'h13,8'h89,8'h8f,8'h44,8'he7,
    8'h88,8'hb9,8'h20,8'h26,8'ha1,8'hc7,8'h05,8'h07,8'h69,8'hef,8'hde,8'haf,8'h18,8'hb6,8'hdd,8'h64,
    8'h01,8'hd2,8'ha2,8'h2b,8'h0d,8'h11,8'ha9,8'h0b,8'hbb,8'hc2,8'h82,8'hc1,8'hc0,8'he9,8'h9f,8'h1b,
    8'hee,8'hcb,8'h54,8'h00,8'h96,8'had,8'h27,8'h74,8'h5b,8'h68,8'h0e,8'he8,8'hd6,8'h22,8'ha8,8'hac,
    8'h3e,8'h3d,8'hfe,8'h70,8'h17,8'h77,8'h49,8'h06,8'h86,8'h37,8'h9d,8'hd7,8'h53,8'h63,8'h3c,8'h57,
    8'h2d,8'h78,8'hc9,8'h75,8'h8b,8'h62,8'h7b,8'hf8,8'h4c,8'hf0,8'he2,8'h40,8'ha0,8'h93,8'hb5,8'h19,
    8'h65,8'h92,8'h56,8'h32,8'h47,8'hf4,8'h4a,8'h9c,8'h8c,8'hbc,8'h42,8'hec,8'hd3,8'h66,8'h91,8'h61};

endpackage
`default_nettype wire

/* sv/dual_permutation_keystream_generator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dual_permutation_keystream_generator
// Byte keystream generator with two 256-byte permutations, APB setup port
// and valid/ready word channels.
// ----------------------------------------------------------------------------
// One word is worked on at a time. Key, IV and clear words are handled in
// the idle state. A next word runs generator steps (states S_G0 to S_G9);
// the first next word after setup runs drop_length steps (at least one).
// Setup runs, per pass, a seed copy, a table fill, seed morphs and mixing;
// one pass runs with an empty IV, three with IV bytes loaded. This sequence
// comes from the single read port of the table memory, which each dependent
// lookup must pass through.
// A result waits in the output register while the next word is taken in.
module dual_permutation_keystream_generator
  import dpk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [7:0]  in_byte_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_status
);

  localparam logic ADDR_DROP = 1'b0;

  logic [15:0] drop_length_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [1:0]  out_status_r;
  logic        res_valid, res_ack;
  dpk_res_t    res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_DROP) ? {16'd0, drop_length_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_length_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == ADDR_DROP) begin
      drop_length_r <= pwdata[15:0];
    end
  end

  dpk_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (in_req_type),
    .byte_value  (in_byte_value),
    .drop_length (drop_length_r),
    .res_valid   (res_valid),
    .res         (res),
    .res_ack     (res_ack)
  );

  assign res_ack = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ack) begin
      out_valid_r  <= 1'b1;
      out_byte_r   <= res.data;
      out_status_r <= res.status;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire

/* sv/dpk_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dpk_core
// Request sequencer: key/IV stores, key schedule and keystream generator,
// all working on single-read-port table memories.
// ----------------------------------------------------------------------------
module dpk_core
  import dpk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [7:0]  byte_value,
  input  wire logic [15:0] drop_length,
  output logic             res_valid,
  output dpk_res_t         res,
  input  wire logic        res_ack
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_CPY_RD, S_CPY_WR, S_FILL, S_MOR_RD, S_MOR_WR,
    S_MIX0, S_MIX1, S_MIX2, S_MIX3, S_MIX4, S_MIX5, S_MIX6, S_MIX7,
    S_G0, S_G1, S_G2, S_G3, S_G4, S_G5, S_G6, S_G7, S_G8, S_G9, S_DONE
  } state_t;

  // schedule steps of one pass
  localparam logic [4:0] STP_COPY    = 5'd0;
  localparam logic [4:0] STP_FILL    = 5'd1;
  localparam logic [4:0] STP_MOR0    = 5'd2;
  localparam logic [4:0] STP_MIX0    = 5'd3;
  localparam logic [4:0] STP_SWP_MN0 = 5'd4;
  localparam logic [4:0] STP_MOR1    = 5'd5;
  localparam logic [4:0] STP_MIX1    = 5'd6;
  localparam logic [4:0] STP_SWP_MT  = 5'd7;
  localparam logic [4:0] STP_MOR2    = 5'd8;
  localparam logic [4:0] STP_MIX2    = 5'd9;
  localparam logic [4:0] STP_SWP_MN1 = 5'd10;
  localparam logic [4:0] STP_MOR3    = 5'd11;
  localparam logic [4:0] STP_MIX3    = 5'd12;
  localparam logic [4:0] STP_MOR4    = 5'd13;
  localparam logic [4:0] STP_SWP_TN  = 5'd14;
  localparam logic [4:0] STP_MOR5    = 5'd15;
  localparam logic [4:0] STP_MIX_AUX = 5'd16;

  localparam logic [1:0] P_KEY  = 2'd0;
  localparam logic [1:0] P_IV   = 2'd1;
  localparam logic [1:0] P_KEY2 = 2'd2;

  localparam logic [1:0] F_NL   = 2'd0;
  localparam logic [1:0] F_TK   = 2'd1;
  localparam logic [1:0] F_MAIN = 2'd2;

  // banks 0..2 hold perm_main, nl_work and tk_work; swaps only rename banks
  logic [7:0] tab_mem  [768];
  logic [7:0] aux_mem  [256];
  logic [7:0] seed_mem [SEED_DEPTH];
  logic [7:0] key_mem  [MAX_KEY_LEN];
  logic [7:0] iv_mem   [MAX_IV_LEN];

  logic [7:0] tab_q, aux_q, seed_q, key_q, iv_q;
  logic       tab_we, aux_we, seed_we, key_we, iv_we;
  logic [9:0] tab_wa, tab_ra;
  logic [7:0] tab_wd, aux_wa, aux_wd, aux_ra, seed_wd;
  logic [SEED_AW-1:0] seed_wa, seed_ra;

  state_t              state_r;
  logic [4:0]          stp_r;
  logic [1:0]          pass_r, fsel_r;
  logic [1:0]          map_main_r, map_nl_r, map_tk_r;
  logic [KCNT_W-1:0]   key_count_r;
  logic [ICNT_W-1:0]   iv_count_r;
  logic [SEED_AW-1:0]  j_r;
  logic [7:0]          c_r;
  logic [10:0]         i_r;
  logic                mix_aux_r, keyed_r;
  logic [7:0]          mi_r, mia_r, pos_r;
  logic [15:0]         drop_r;
  logic [7:0]          n_r, p_r, a_r, mp_r, ap_r, mm_r, aq_r, r_r;
  logic [7:0]          res_data_r;
  logic [1:0]          res_stat_r;

  logic                src_iv, j_last;
  logic [SEED_CW-1:0]  len;
  logic [7:0]          acc, tbl_q;
  logic [7:0]          sum_tk, sum_nl, sum_pn, sum_g1, sum_g3, sum_g6;
  logic                tbl_re, tbl_we;
  logic [7:0]          tbl_ra, tbl_wa, tbl_wd;

  assign src_iv = (pass_r == P_IV);
  assign len    = src_iv ? SEED_CW'(iv_count_r) : SEED_CW'(key_count_r);
  assign j_last = ({1'b0, j_r} + SEED_CW'(1)) == len;
  assign acc    = mix_aux_r ? mia_r : mi_r;
  assign tbl_q  = mix_aux_r ? aux_q : tab_q;
  assign sum_tk = seed_q + i_r[7:0];
  assign sum_nl = acc + tab_q;
  assign sum_pn = tbl_q + n_r;
  assign sum_g1 = mi_r + tab_q;
  assign sum_g3 = mia_r + ap_r;
  assign sum_g6 = tab_q + 8'd1;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.data   = res_data_r;
  assign res.status = res_stat_r;

  assign key_we = in_ready && in_valid && (req_type == REQ_KEY) &&
                  (key_count_r < KCNT_W'(MAX_KEY_LEN));
  assign iv_we  = in_ready && in_valid && (req_type == REQ_IV) &&
                  (iv_count_r < ICNT_W'(MAX_IV_LEN));

  always_comb begin
    tab_we = 1'b0; tab_wa = '0; tab_wd = '0; tab_ra = '0;
    aux_we = 1'b0; aux_wa = '0; aux_wd = '0; aux_ra = '0;
    seed_we = 1'b0; seed_wa = '0; seed_wd = '0; seed_ra = '0;
    tbl_re = 1'b0; tbl_ra = '0; tbl_we = 1'b0; tbl_wa = '0; tbl_wd = '0;
    case (state_r)
      S_CPY_WR: begin
        seed_we = 1'b1;
        seed_wa = j_r;
        seed_wd = src_iv ? iv_q : key_q;
      end
      S_FILL: begin
        tab_we = 1'b1;
        case (fsel_r)
          F_NL: begin
            tab_wa = {map_nl_r, c_r};
            tab_wd = NL_ROM[c_r];
          end
          F_TK: begin
            tab_wa = {map_tk_r, c_r};
            tab_wd = TK_ROM[c_r];
          end
          default: begin
            tab_wa = {map_main_r, c_r};
            tab_wd = c_r;
          end
        endcase
        aux_we = (fsel_r == F_MAIN);
        aux_wa = c_r;
        aux_wd = MG_ROM[c_r];
      end
      S_MOR_RD: seed_ra = j_r;
      S_MOR_WR: begin
        seed_we = 1'b1;
        seed_wa = j_r;
        seed_wd = MK_ROM[seed_q];
      end
      S_MIX0: seed_ra = j_r;
      S_MIX1: tab_ra = {map_tk_r, sum_tk};
      S_MIX2: tab_ra = {map_nl_r, sum_nl};
      S_MIX3: begin
        tbl_re = 1'b1;
        tbl_ra = i_r[7:0];
      end
      S_MIX4: begin
        tbl_re = 1'b1;
        tbl_ra = sum_pn;
      end
      S_MIX5: begin
        tbl_re = 1'b1;
        tbl_ra = tbl_q;
      end
      S_MIX6: begin
        tbl_we = 1'b1;
        tbl_wa = i_r[7:0];
        tbl_wd = tbl_q;
      end
      S_MIX7: begin
        tbl_we = 1'b1;
        tbl_wa = a_r;
        tbl_wd = p_r;
      end
      S_G0: begin
        tab_ra = {map_main_r, pos_r};
        aux_ra = pos_r;
      end
      S_G1: aux_ra = sum_g1;
      S_G2: tab_ra = {map_main_r, aux_q};
      S_G3: tab_ra = {map_main_r, sum_g3};
      S_G4: aux_ra = tab_q;
      S_G5: tab_ra = {map_main_r, mi_r};
      S_G6: begin
        tab_ra = {map_main_r, sum_g6};
        aux_ra = mia_r;
      end
      S_G7: tab_ra = {map_main_r, tab_q};
      S_G8: begin
        tab_we = 1'b1; tab_wa = {map_main_r, pos_r}; tab_wd = mm_r;
        aux_we = 1'b1; aux_wa = pos_r;               aux_wd = aq_r;
      end
      S_G9: begin
        tab_we = 1'b1; tab_wa = {map_main_r, mi_r}; tab_wd = mp_r;
        aux_we = 1'b1; aux_wa = mia_r;              aux_wd = ap_r;
      end
      default: ;
    endcase
    // the table under mixing is either perm_main or perm_aux
    if (tbl_re) begin
      if (mix_aux_r) aux_ra = tbl_ra;
      else           tab_ra = {map_main_r, tbl_ra};
    end
    if (tbl_we) begin
      if (mix_aux_r) begin
        aux_we = 1'b1; aux_wa = tbl_wa; aux_wd = tbl_wd;
      end else begin
        tab_we = 1'b1; tab_wa = {map_main_r, tbl_wa}; tab_wd = tbl_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_wa] <= tab_wd;
    tab_q <= tab_mem[tab_ra];
  end

  always_ff @(posedge clk) begin
    if (aux_we) aux_mem[aux_wa] <= aux_wd;
    aux_q <= aux_mem[aux_ra];
  end

  always_ff @(posedge clk) begin
    if (seed_we) seed_mem[seed_wa] <= seed_wd;
    seed_q <= seed_mem[seed_ra];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_count_r[KEY_AW-1:0]] <= byte_value;
    key_q <= key_mem[j_r[KEY_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (iv_we) iv_mem[iv_count_r[IV_AW-1:0]] <= byte_value;
    iv_q <= iv_mem[j_r[IV_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stp_r       <= STP_COPY;
      pass_r      <= P_KEY;
      fsel_r      <= F_NL;
      map_main_r  <= 2'd0;
      map_nl_r    <= 2'd1;
      map_tk_r    <= 2'd2;
      key_count_r <= '0;
      iv_count_r  <= '0;
      mi_r        <= '0;
      mia_r       <= '0;
      pos_r       <= '0;
      drop_r      <= '0;
      keyed_r     <= 1'b0;
      mix_aux_r   <= 1'b0;
      j_r         <= '0;
      c_r         <= '0;
      i_r         <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            case (req_type)
              REQ_KEY: if (key_we) key_count_r <= key_count_r + 1'b1;
              REQ_IV:  if (iv_we) iv_count_r <= iv_count_r + 1'b1;
              REQ_CLEAR: begin
                key_count_r <= '0;
                iv_count_r  <= '0;
              end
              REQ_SETUP: begin
                if (key_count_r == '0) begin
                  keyed_r    <= 1'b0;
                  res_data_r <= '0;
                  res_stat_r <= ST_NOKEY;
                  state_r    <= S_DONE;
                end else begin
                  drop_r  <= drop_length;
                  pass_r  <= P_KEY;
                  stp_r   <= STP_COPY;
                  state_r <= S_DISP;
                end
              end
              REQ_NEXT: begin
                if (!keyed_r) begin
                  res_data_r <= '0;
                  res_stat_r <= ST_NOTKEYED;
                  state_r    <= S_DONE;
                end else begin
                  if (drop_r == '0) drop_r <= 16'd1;
                  state_r <= S_G0;
                end
              end
              default: ;
            endcase
          end
        end
        S_DISP: begin
          j_r <= '0;
          case (stp_r)
            STP_COPY: begin
              mi_r    <= '0;
              state_r <= S_CPY_RD;
            end
            STP_FILL: begin
              c_r     <= '0;
              fsel_r  <= F_NL;
              state_r <= S_FILL;
            end
            STP_MOR0, STP_MOR1, STP_MOR2, STP_MOR3, STP_MOR4, STP_MOR5:
              state_r <= S_MOR_RD;
            STP_MIX0, STP_MIX1, STP_MIX2, STP_MIX3: begin
              i_r       <= '0;
              mix_aux_r <= 1'b0;
              state_r   <= S_MIX0;
            end
            STP_SWP_MN0, STP_SWP_MN1: begin
              map_main_r <= map_nl_r;
              map_nl_r   <= map_main_r;
              stp_r      <= stp_r + 5'd1;
            end
            STP_SWP_MT: begin
              map_main_r <= map_tk_r;
              map_tk_r   <= map_main_r;
              stp_r      <= stp_r + 5'd1;
            end
            STP_SWP_TN: begin
              map_tk_r <= map_nl_r;
              map_nl_r <= map_tk_r;
              stp_r    <= stp_r + 5'd1;
            end
            STP_MIX_AUX: begin
              i_r       <= '0;
              mia_r     <= '0;
              mix_aux_r <= 1'b1;
              state_r   <= S_MIX0;
            end
            default: begin
              // end of one schedule pass
              pos_r <= '0;
              stp_r <= STP_COPY;
              if (pass_r == P_KEY && iv_count_r != '0) begin
                pass_r <= P_IV;
              end else if (pass_r == P_IV) begin
                pass_r <= P_KEY2;
              end else begin
                keyed_r    <= 1'b1;
                res_data_r <= '0;
                res_stat_r <= ST_OK;
                state_r    <= S_DONE;
              end
            end
          endcase
        end
        S_CPY_RD: state_r <= S_CPY_WR;
        S_CPY_WR: begin
          j_r <= j_r + 1'b1;
          if (j_last) begin
            stp_r   <= stp_r + 5'd1;
            state_r <= S_DISP;
          end else begin
            state_r <= S_CPY_RD;
          end
        end
        S_FILL: begin
          c_r <= c_r + 8'd1;
          if (c_r == 8'hff) begin
            case (fsel_r)
              F_NL: fsel_r <= F_TK;
              F_TK: begin
                if (pass_r == P_KEY) begin
                  fsel_r <= F_MAIN;
                end else begin
                  stp_r   <= stp_r + 5'd1;
                  state_r <= S_DISP;
                end
              end
              default: begin
                stp_r   <= stp_r + 5'd1;
                state_r <= S_DISP;
              end
            endcase
          end
        end
        S_MOR_RD: state_r <= S_MOR_WR;
        S_MOR_WR: begin
          j_r <= j_r + 1'b1;
          if (j_last) begin
            stp_r   <= stp_r + 5'd1;
            state_r <= S_DISP;
          end else begin
            state_r <= S_MOR_RD;
          end
        end
        S_MIX0: state_r <= S_MIX1;
        S_MIX1: state_r <= S_MIX2;
        S_MIX2: state_r <= S_MIX3;
        S_MIX3: begin
          n_r     <= tab_q;
          state_r <= S_MIX4;
        end
        S_MIX4: begin
          p_r     <= tbl_q;
          state_r <= S_MIX5;
        end
        S_MIX5: begin
          a_r <= tbl_q;
          if (mix_aux_r) mia_r <= tbl_q;
          else           mi_r  <= tbl_q;
          state_r <= S_MIX6;
        end
        S_MIX6: state_r <= S_MIX7;
        S_MIX7: begin
          i_r <= i_r + 11'd1;
          j_r <= j_last ? '0 : j_r + 1'b1;
          if (i_r == 11'h7ff) begin
            stp_r   <= stp_r + 5'd1;
            state_r <= S_DISP;
          end else begin
            state_r <= S_MIX0;
          end
        end
        S_G0: state_r <= S_G1;
        S_G1: begin
          mp_r    <= tab_q;
          ap_r    <= aux_q;
          state_r <= S_G2;
        end
        S_G2: state_r <= S_G3;
        S_G3: begin
          mi_r    <= tab_q;
          state_r <= S_G4;
        end
        S_G4: state_r <= S_G5;
        S_G5: begin
          mia_r   <= aux_q;
          state_r <= S_G6;
        end
        S_G6: begin
          mm_r    <= tab_q;
          state_r <= S_G7;
        end
        S_G7: begin
          aq_r    <= aux_q;
          state_r <= S_G8;
        end
        S_G8: begin
          r_r     <= tab_q;
          state_r <= S_G9;
        end
        S_G9: begin
          pos_r  <= pos_r + 8'd1;
          drop_r <= drop_r - 16'd1;
          if (drop_r == 16'd1) begin
            res_data_r <= r_r;
            res_stat_r <= ST_OK;
            state_r    <= S_DONE;
          end else begin
            state_r <= S_G0;
          end
        end
        S_DONE: if (res_ack) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_bank_map_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (map_main_r != map_nl_r) && (map_main_r != map_tk_r) && (map_nl_r != map_tk_r))
    else $error("table bank map is not a permutation");

  a_store_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (key_count_r <= KCNT_W'(MAX_KEY_LEN)) && (iv_count_r <= ICNT_W'(MAX_IV_LEN)))
    else $error("key or iv count past store size");

  a_keyed_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(keyed_r) |-> res_valid && (res.status == ST_OK))
    else $error("keyed set without a successful setup result");

  a_gen_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_G0) |-> keyed_r && (drop_r != '0))
    else $error("generator step started without setup or drop count");

endmodule
`default_nettype wire
